### src/lcar_pkg.sv
package lcar_pkg;

	// Fixed widths of the converter word, config port and result
	localparam int SAMPLE_BITS        = 24;
	localparam int SAMPLES_PER_RESULT = 2;
	localparam int CFG_W              = 24;
	localparam int CFG_IDX_W          = 2;
	localparam int HIGH_W             = 8;
	localparam int BIT_CNT_W          = 5;
	localparam int GRAMS_W            = 32;
	localparam int FRAC_BITS          = 8;
	localparam int DIV_W              = 32;
	localparam int DIV_CNT_W          = $clog2(DIV_W);
	localparam int PC_W               = 4;

	localparam logic [SAMPLE_BITS-1:0] SIGN_FLIP = SAMPLE_BITS'(1) << (SAMPLE_BITS - 1);
	localparam logic [SAMPLE_BITS-1:0] MAX_POS   = SIGN_FLIP - SAMPLE_BITS'(1);

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_ZERO_OFFSET      = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_COUNTS_PER_GRAM  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CLOCK_HIGH_TICKS = 2'd2;

	// Program addresses
	localparam logic [PC_W-1:0] ST_WAIT      = 4'd0;
	localparam logic [PC_W-1:0] ST_HIGH      = 4'd1;
	localparam logic [PC_W-1:0] ST_LOW       = 4'd2;
	localparam logic [PC_W-1:0] ST_DECIDE    = 4'd3;
	localparam logic [PC_W-1:0] ST_AVG_LOAD  = 4'd4;
	localparam logic [PC_W-1:0] ST_AVG_DIV   = 4'd5;
	localparam logic [PC_W-1:0] ST_TARE      = 4'd6;
	localparam logic [PC_W-1:0] ST_GRAM_LOAD = 4'd7;
	localparam logic [PC_W-1:0] ST_GRAM_DIV  = 4'd8;
	localparam logic [PC_W-1:0] ST_EMIT      = 4'd9;

	typedef enum logic [3:0] {
		OP_WAIT,
		OP_HIGH,
		OP_LOW,
		OP_DECIDE,
		OP_AVG_LOAD,
		OP_DIV_STEP,
		OP_TARE,
		OP_GRAM_LOAD,
		OP_EMIT
	} uop_t;

	typedef enum logic [2:0] {
		C_ALWAYS,
		C_LEVEL_HIGH,
		C_TICK_MORE,
		C_BITS_LEFT,
		C_DIV_NEEDED,
		C_DIV_MORE,
		C_AT_OR_BELOW
	} cond_t;

	typedef struct packed {
		uop_t            op;
		logic            consume;
		cond_t           cond;
		logic [PC_W-1:0] target_t;
		logic [PC_W-1:0] target_f;
	} uword_t;

	// Control store: one word per step
	function automatic uword_t ucode(logic [PC_W-1:0] pc);
		uword_t w;
		w = '{OP_WAIT, 1'b1, C_LEVEL_HIGH, ST_WAIT, ST_HIGH};
		unique case (pc)
			ST_WAIT:      w = '{OP_WAIT,      1'b1, C_LEVEL_HIGH,  ST_WAIT,     ST_HIGH};
			ST_HIGH:      w = '{OP_HIGH,      1'b1, C_TICK_MORE,   ST_HIGH,     ST_LOW};
			ST_LOW:       w = '{OP_LOW,       1'b1, C_BITS_LEFT,   ST_HIGH,     ST_DECIDE};
			ST_DECIDE:    w = '{OP_DECIDE,    1'b0, C_DIV_NEEDED,  ST_AVG_LOAD, ST_WAIT};
			ST_AVG_LOAD:  w = '{OP_AVG_LOAD,  1'b0, C_ALWAYS,      ST_AVG_DIV,  ST_AVG_DIV};
			ST_AVG_DIV:   w = '{OP_DIV_STEP,  1'b0, C_DIV_MORE,    ST_AVG_DIV,  ST_TARE};
			ST_TARE:      w = '{OP_TARE,      1'b0, C_AT_OR_BELOW, ST_WAIT,     ST_GRAM_LOAD};
			ST_GRAM_LOAD: w = '{OP_GRAM_LOAD, 1'b0, C_ALWAYS,      ST_GRAM_DIV, ST_GRAM_DIV};
			ST_GRAM_DIV:  w = '{OP_DIV_STEP,  1'b0, C_DIV_MORE,    ST_GRAM_DIV, ST_EMIT};
			ST_EMIT:      w = '{OP_EMIT,      1'b0, C_ALWAYS,      ST_WAIT,     ST_WAIT};
			default:      w = '{OP_WAIT,      1'b0, C_ALWAYS,      ST_WAIT,     ST_WAIT};
		endcase
		return w;
	endfunction

endpackage

### src/load_cell_adc_reader_core.sv
// A tick's output beat is registered and shows in the cycle after the tick is taken.
// Throughput: one tick per cycle through the pulse train unless a stalled beat blocks it;
// the tick that ends a conversion also takes the decide step; one that completes a result
// with a good sample adds the shared divider's 32-step passes, grams only above the tare.
// Reset: arst_n clears the sequencer, counters, accumulators and the output register,
// and loads zero_offset 0, counts_per_gram 1, clock_high_ticks 1.
module load_cell_adc_reader_core #(
	parameter int SAMPLES_PER_RESULT = lcar_pkg::SAMPLES_PER_RESULT
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic                           data_level,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic                           serial_clock,
	output logic                           weight_valid,
	output logic [lcar_pkg::GRAMS_W-1:0]   weight_grams,
	output logic                           no_valid_sample,
	input  logic                           cfg_we,
	input  logic [lcar_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [lcar_pkg::CFG_W-1:0]     cfg_data
);
	import lcar_pkg::*;

	localparam int CNT_W = $clog2(SAMPLES_PER_RESULT + 1);
	localparam int SUM_W = SAMPLE_BITS + CNT_W;

	// Config registers
	logic [SAMPLE_BITS-1:0] zero_offset_q;
	logic [SAMPLE_BITS-1:0] counts_per_gram_q;
	logic [HIGH_W-1:0]      clock_high_ticks_q;

	// Sequencer and datapath
	logic [PC_W-1:0]        pc_q;
	logic [BIT_CNT_W-1:0]   bit_count_q;
	logic [HIGH_W-1:0]      tick_count_q;
	logic [SAMPLE_BITS-1:0] shift_word_q;
	logic [SUM_W-1:0]       sample_sum_q;
	logic [CNT_W-1:0]       valid_count_q;
	logic [CNT_W-1:0]       attempt_count_q;
	logic [SAMPLE_BITS-1:0] div_rem_q;
	logic [SAMPLE_BITS-1:0] div_den_q;
	logic [DIV_W-1:0]       div_quot_q;
	logic [DIV_CNT_W-1:0]   div_cnt_q;

	// Output register
	logic                   out_valid_q;
	logic                   serial_clock_q;
	logic                   weight_valid_q;
	logic [GRAMS_W-1:0]     weight_grams_q;
	logic                   no_valid_sample_q;

	uword_t                 uw;
	logic                   out_free;
	logic                   fire;
	logic                   cond_hit;
	logic [HIGH_W-1:0]      high_len;
	logic [HIGH_W-1:0]      tick_next;
	logic                   tick_more;
	logic                   bits_left;
	logic [SAMPLE_BITS-1:0] sample_ob;
	logic                   sample_ok;
	logic                   last_attempt;
	logic                   div_needed;
	logic [SAMPLE_BITS:0]   rem_shift;
	logic                   rem_ge;
	logic [SAMPLE_BITS:0]   rem_sub;
	logic [SAMPLE_BITS-1:0] avg;
	logic                   at_or_below;
	logic                   emit;
	logic                   emit_clk;
	logic                   emit_wv;
	logic                   emit_nv;
	logic [GRAMS_W-1:0]     emit_grams;

	assign uw       = ucode(pc_q);
	assign out_free = !out_valid_q || !out_stall;
	assign fire     = out_free && (!uw.consume || in_valid);
	assign in_stall = !(uw.consume && out_free);

	// Pulse timing and sample checks
	assign high_len     = (clock_high_ticks_q == '0) ? HIGH_W'(1) : clock_high_ticks_q;
	assign tick_next    = tick_count_q + HIGH_W'(1);
	assign tick_more    = tick_next < high_len;
	assign bits_left    = bit_count_q < BIT_CNT_W'(SAMPLE_BITS);
	assign sample_ob    = shift_word_q ^ SIGN_FLIP;
	assign sample_ok    = (sample_ob != '0) && (sample_ob != MAX_POS);
	assign last_attempt = attempt_count_q >= CNT_W'(SAMPLES_PER_RESULT);
	assign div_needed   = last_attempt && (valid_count_q != '0);

	// Restoring divider step
	assign rem_shift   = {div_rem_q, div_quot_q[DIV_W-1]};
	assign rem_ge      = rem_shift >= {1'b0, div_den_q};
	assign rem_sub     = rem_shift - {1'b0, div_den_q};
	assign avg         = div_quot_q[SAMPLE_BITS-1:0];
	assign at_or_below = avg <= zero_offset_q;

	// Branch condition
	always_comb begin
		unique case (uw.cond)
			C_ALWAYS:      cond_hit = 1'b1;
			C_LEVEL_HIGH:  cond_hit = data_level;
			C_TICK_MORE:   cond_hit = tick_more;
			C_BITS_LEFT:   cond_hit = bits_left;
			C_DIV_NEEDED:  cond_hit = div_needed;
			C_DIV_MORE:    cond_hit = div_cnt_q != DIV_CNT_W'(DIV_W - 1);
			C_AT_OR_BELOW: cond_hit = at_or_below;
			default:       cond_hit = 1'b1;
		endcase
	end

	// Output beat produced by this step
	always_comb begin
		emit       = 1'b0;
		emit_clk   = 1'b0;
		emit_wv    = 1'b0;
		emit_nv    = 1'b0;
		emit_grams = '0;
		unique case (uw.op)
			OP_WAIT:   emit = 1'b1;
			OP_HIGH: begin
				emit     = 1'b1;
				emit_clk = 1'b1;
			end
			OP_LOW:    emit = bits_left;
			OP_DECIDE: begin
				emit    = !div_needed;
				emit_wv = last_attempt;
				emit_nv = last_attempt;
			end
			OP_TARE: begin
				emit    = at_or_below;
				emit_wv = 1'b1;
			end
			OP_EMIT: begin
				emit       = 1'b1;
				emit_wv    = 1'b1;
				emit_grams = div_quot_q;
			end
			default:   emit = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			zero_offset_q      <= '0;
			counts_per_gram_q  <= SAMPLE_BITS'(1);
			clock_high_ticks_q <= HIGH_W'(1);
			pc_q               <= ST_WAIT;
			bit_count_q        <= '0;
			tick_count_q       <= '0;
			shift_word_q       <= '0;
			sample_sum_q       <= '0;
			valid_count_q      <= '0;
			attempt_count_q    <= '0;
			div_rem_q          <= '0;
			div_den_q          <= '0;
			div_quot_q         <= '0;
			div_cnt_q          <= '0;
			out_valid_q        <= 1'b0;
			serial_clock_q     <= 1'b0;
			weight_valid_q     <= 1'b0;
			weight_grams_q     <= '0;
			no_valid_sample_q  <= 1'b0;
		end else begin
			// Config writes
			if (cfg_we) begin
				case (cfg_index)
					REG_ZERO_OFFSET:      zero_offset_q      <= cfg_data[SAMPLE_BITS-1:0];
					REG_COUNTS_PER_GRAM:  counts_per_gram_q  <= cfg_data[SAMPLE_BITS-1:0];
					REG_CLOCK_HIGH_TICKS: clock_high_ticks_q <= cfg_data[HIGH_W-1:0];
					default: ;
				endcase
			end

			// Raise valid on a new beat, drop the held beat once taken
			if (fire && emit)
				out_valid_q <= 1'b1;
			else if (out_valid_q && !out_stall)
				out_valid_q <= 1'b0;

			if (fire) begin
				pc_q <= cond_hit ? uw.target_t : uw.target_f;

				unique case (uw.op)
					OP_WAIT: begin
						if (!data_level) begin
							bit_count_q  <= '0;
							tick_count_q <= '0;
							shift_word_q <= '0;
						end
					end
					OP_HIGH: begin
						tick_count_q <= tick_more ? tick_next : '0;
					end
					OP_LOW: begin
						if (bits_left) begin
							shift_word_q <= {shift_word_q[SAMPLE_BITS-2:0], data_level};
							bit_count_q  <= bit_count_q + BIT_CNT_W'(1);
						end else begin
							// Close the conversion and accumulate a good sample
							if (sample_ok) begin
								sample_sum_q  <= sample_sum_q + SUM_W'(sample_ob);
								valid_count_q <= valid_count_q + CNT_W'(1);
							end
							attempt_count_q <= attempt_count_q + CNT_W'(1);
							bit_count_q     <= '0;
							tick_count_q    <= '0;
							shift_word_q    <= '0;
						end
					end
					OP_DECIDE: begin
						if (last_attempt && !div_needed) begin
							sample_sum_q    <= '0;
							valid_count_q   <= '0;
							attempt_count_q <= '0;
						end
					end
					OP_AVG_LOAD: begin
						div_quot_q      <= DIV_W'(sample_sum_q);
						div_den_q       <= SAMPLE_BITS'(valid_count_q);
						div_rem_q       <= '0;
						div_cnt_q       <= '0;
						sample_sum_q    <= '0;
						valid_count_q   <= '0;
						attempt_count_q <= '0;
					end
					OP_DIV_STEP: begin
						div_rem_q  <= rem_ge ? rem_sub[SAMPLE_BITS-1:0]
						                     : rem_shift[SAMPLE_BITS-1:0];
						div_quot_q <= {div_quot_q[DIV_W-2:0], rem_ge};
						div_cnt_q  <= div_cnt_q + DIV_CNT_W'(1);
					end
					OP_GRAM_LOAD: begin
						div_quot_q <= {avg - zero_offset_q, FRAC_BITS'(0)};
						div_den_q  <= (counts_per_gram_q == '0) ? SAMPLE_BITS'(1)
						                                       : counts_per_gram_q;
						div_rem_q  <= '0;
						div_cnt_q  <= '0;
					end
					default: ;
				endcase

				// Load the output register
				if (emit) begin
					serial_clock_q    <= emit_clk;
					weight_valid_q    <= emit_wv;
					weight_grams_q    <= emit_grams;
					no_valid_sample_q <= emit_nv;
				end
			end
		end
	end

	assign out_valid       = out_valid_q;
	assign serial_clock    = serial_clock_q;
	assign weight_valid    = weight_valid_q;
	assign weight_grams    = weight_grams_q;
	assign no_valid_sample = no_valid_sample_q;

endmodule

### src/lcar_checker.sv
module lcar_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           in_stall,
	input logic                           out_valid,
	input logic                           out_stall,
	input logic                           serial_clock,
	input logic                           weight_valid,
	input logic [lcar_pkg::GRAMS_W-1:0]   weight_grams,
	input logic                           no_valid_sample
);
	import lcar_pkg::*;

	// A plain tick beat carries no weight or error
	a_plain_beat_clear: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !weight_valid |-> weight_grams == '0 && !no_valid_sample)
		else $error("plain tick beat carries weight or error");

	// An error beat is a result beat with zero weight
	a_error_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && no_valid_sample |-> weight_valid && weight_grams == '0)
		else $error("error beat without result or with weight");

	// Results come only on a low serial clock tick
	a_result_clock_low: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && weight_valid |-> !serial_clock)
		else $error("result beat with serial clock high");

	// Hold ticks off while an output beat is blocked
	a_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |-> in_stall)
		else $error("tick taken while output beat is blocked");

	// Stalled beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(weight_grams) && $stable(weight_valid))
		else $error("stalled output beat changed");

endmodule

bind load_cell_adc_reader_core lcar_checker u_lcar_checker (.*);

### tb/sv/load_cell_adc_reader_core_tb.sv
`timescale 1ns / 1ps

module load_cell_adc_reader_core_tb;
	import lcar_pkg::*;

	localparam int LIMIT_CYCLES = 1_500_000;
	localparam int LONG_HOLD    = 300;
	localparam int RANDOM_TICKS = 200;
	localparam int WEIGHT_GOAL  = 6;
	localparam int QUIET_AFTER  = 5;
	localparam int SETTLE       = 100;

	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

	typedef enum logic [1:0] {TR_IDLE, TR_HIGH, TR_LOW} train_t;

	// one output beat of the reader
	typedef struct packed {
		logic               sclk;
		logic               wvalid;
		logic [GRAMS_W-1:0] grams;
		logic               novalid;
	} reader_beat_t;

	// one directed weighing: optional register setup, then two conversions
	typedef struct packed {
		logic                   wr;
		logic [CFG_W-1:0]       tare_v;
		logic [CFG_W-1:0]       scale_v;
		logic [HIGH_W-1:0]      high_v;
		logic [SAMPLE_BITS-1:0] word_a;
		logic [SAMPLE_BITS-1:0] word_b;
		logic [2:0]             lead;
		logic                   typed;
		logic [GRAMS_W-1:0]     grams;
		logic                   novalid;
	} weighing_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 in_valid = 1'b0;
	logic                 in_stall;
	logic                 data_level = 1'b1;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	logic                 serial_clock;
	logic                 weight_valid;
	logic [GRAMS_W-1:0]   weight_grams;
	logic                 no_valid_sample;
	logic                 cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0]     cfg_data = '0;

	// shadow registers and reader state
	logic [CFG_W-1:0]       tare;
	logic [CFG_W-1:0]       scale;
	logic [HIGH_W-1:0]      high_ticks;
	train_t                 tr_phase;
	logic [BIT_CNT_W-1:0]   bits_in;
	logic [HIGH_W-1:0]      pulse_ticks;
	logic [SAMPLE_BITS-1:0] shift_acc;
	logic [63:0]            sample_acc;
	logic [1:0]             good_samples;
	logic [1:0]             attempts;

	reader_beat_t beat_q[$];

	// typed weight for the current directed weighing
	logic               typed_on = 1'b0;
	logic [GRAMS_W-1:0] typed_grams;
	logic               typed_nv;

	logic idle_bursts_on = 1'b1;
	logic hold_req = 1'b0;
	int   hold_left = 0;
	int   burst_left = 0;
	int   cycles = 0;
	int   mismatches = 0;
	int   beats_seen = 0;
	int   n_accepted = 0;
	int   n_ticks = 0;
	int   n_weights = 0;
	int   n_novalid = 0;
	int   n_tared = 0;
	int   n_writes = 0;

	weighing_t plan [4] = '{
		'{1'b0, 24'h000000, 24'h000001, 8'd1,   24'h000000, 24'h000000, 3'd0,
			1'b1, 32'h8000_0000, 1'b0},
		'{1'b0, 24'h000000, 24'h000001, 8'd1,   24'h800000, 24'hFFFFFF, 3'd1,
			1'b1, 32'h0000_0000, 1'b1},
		'{1'b1, 24'hFFFFFF, 24'hFFFFFF, 8'd0,   24'h7FFFFF, 24'h7FFFFF, 3'd2,
			1'b1, 32'h0000_0000, 1'b0},
		'{1'b1, 24'hFFFFFE, 24'h000000, 8'd1,   24'hFFFFFF, 24'h7FFFFF, 3'd0,
			1'b1, 32'h0000_0100, 1'b0}
	};

	load_cell_adc_reader_core dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.data_level      (data_level),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.serial_clock    (serial_clock),
		.weight_valid    (weight_valid),
		.weight_grams    (weight_grams),
		.no_valid_sample (no_valid_sample),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// advance the reader by one tick and return the beat it gives
	function automatic reader_beat_t scale_tick(input logic lvl);
		reader_beat_t    b;
		logic [HIGH_W-1:0] high_len;
		logic [SAMPLE_BITS-1:0] v;
		logic [63:0]     avg;
		logic [63:0]     div;
		logic [63:0]     q;
		b = '0;
		high_len = (high_ticks == '0) ? HIGH_W'(1) : high_ticks;
		case (tr_phase)
			TR_HIGH: begin
				b.sclk = 1'b1;
				pulse_ticks = pulse_ticks + HIGH_W'(1);
				if (pulse_ticks >= high_len) begin
					pulse_ticks = '0;
					tr_phase = TR_LOW;
				end
			end
			TR_LOW: begin
				if (bits_in < BIT_CNT_W'(SAMPLE_BITS)) begin
					shift_acc = {shift_acc[SAMPLE_BITS-2:0], lvl};
					bits_in = bits_in + BIT_CNT_W'(1);
					tr_phase = TR_HIGH;
				end else begin
					// drop the stuck-at words, keep the rest
					v = shift_acc ^ SIGN_FLIP;
					if (v != '0 && v != MAX_POS) begin
						sample_acc = sample_acc + 64'(v);
						good_samples = good_samples + 2'(1);
					end
					attempts = attempts + 2'(1);
					if (attempts >= 2'(SAMPLES_PER_RESULT)) begin
						b.wvalid = 1'b1;
						if (good_samples == '0) begin
							b.novalid = 1'b1;
						end else begin
							avg = sample_acc / 64'(good_samples);
							div = (scale == '0) ? 64'd1 : 64'(scale);
							if (avg > 64'(tare)) begin
								q = ((avg - 64'(tare)) << FRAC_BITS) / div;
								b.grams = (q > 64'hFFFF_FFFF) ? '1 : q[GRAMS_W-1:0];
							end
						end
						sample_acc = '0;
						good_samples = '0;
						attempts = '0;
					end
					bits_in = '0;
					pulse_ticks = '0;
					shift_acc = '0;
					tr_phase = TR_IDLE;
				end
			end
			default: begin
				if (!lvl) begin
					bits_in = '0;
					pulse_ticks = '0;
					shift_acc = '0;
					tr_phase = TR_HIGH;
				end
			end
		endcase
		return b;
	endfunction

	// offer one tick, wait for the tick to be taken, record what it should give
	task automatic put_tick(input logic lvl);
		reader_beat_t b;
		logic         ignored;
		data_level <= lvl;
		in_valid <= 1'b1;
		do @(posedge clk); while (in_stall);
		ignored = (tr_phase == TR_IDLE) && lvl;
		b = scale_tick(lvl);
		if (b.wvalid) begin
			if (typed_on) begin
				b.grams = typed_grams;
				b.novalid = typed_nv;
			end
			n_weights++;
			if (b.novalid)
				n_novalid++;
			else if (b.grams == '0)
				n_tared++;
		end
		beat_q.push_back(b);
		n_accepted++;
		if (!ignored)
			n_ticks++;
		if (idle_bursts_on && $urandom_range(0, 5) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
	endtask

	// one conversion: idle highs, start low, then the pulse train carrying word
	task automatic convert(input logic [SAMPLE_BITS-1:0] word, input int lead);
		repeat (lead) put_tick(1'b1);
		put_tick(1'b0);
		while (tr_phase != TR_IDLE) begin
			if (tr_phase == TR_LOW && bits_in < BIT_CNT_W'(SAMPLE_BITS))
				put_tick(word[SAMPLE_BITS-1-bits_in]);
			else
				put_tick(1'($urandom_range(0, 1)));
		end
	endtask

	// stop offering and wait until every beat has come back
	task automatic drain();
		in_valid <= 1'b0;
		while (beat_q.size() != 0) @(posedge clk);
	endtask

	// write the registers selected by mask, in index order; we stays high across
	task automatic set_regs(input logic [CFG_W-1:0] t, input logic [CFG_W-1:0] s,
			input logic [HIGH_W-1:0] h, input logic [3:0] mask);
		logic [CFG_IDX_W-1:0] idx [4];
		logic [CFG_W-1:0]     val [4];
		logic [15:0]          pad;
		pad = 16'($urandom);
		idx = '{REG_ZERO_OFFSET, REG_COUNTS_PER_GRAM, REG_CLOCK_HIGH_TICKS, REG_UNUSED};
		val = '{t, s, {pad, h}, CFG_W'($urandom)};
		for (int i = 0; i < 4; i++) begin
			if (mask[i]) begin
				cfg_we <= 1'b1;
				cfg_index <= idx[i];
				cfg_data <= val[i];
				@(posedge clk);
				case (idx[i])
					REG_ZERO_OFFSET:      tare = val[i];
					REG_COUNTS_PER_GRAM:  scale = val[i];
					REG_CLOCK_HIGH_TICKS: high_ticks = val[i][HIGH_W-1:0];
					default: ;
				endcase
				n_writes++;
			end
		end
		cfg_we <= 1'b0;
	endtask

	// pick a converter word, biased toward the stuck-at codes and the tare
	function automatic logic [SAMPLE_BITS-1:0] pick_word();
		case ($urandom_range(0, 9))
			0:       return 24'h800000;
			1:       return 24'hFFFFFF;
			2:       return 24'h7FFFFF;
			3:       return 24'h000000;
			4:       return (tare + 24'($urandom_range(0, 2)) - 24'd1) ^ SIGN_FLIP;
			default: return SAMPLE_BITS'($urandom);
		endcase
	endfunction

	// receiver: one long hold on request, short random stall bursts otherwise
	always @(posedge clk) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else if (hold_req) begin
			hold_req = 1'b0;
			hold_left <= LONG_HOLD - 1;
			out_stall <= 1'b1;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			out_stall <= 1'b1;
		end else if (burst_left != 0) begin
			burst_left <= burst_left - 1;
			out_stall <= 1'b1;
		end else if (idle_bursts_on && $urandom_range(0, 6) == 0) begin
			burst_left <= $urandom_range(0, 2);
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	// compare each taken beat with the oldest pending one
	always @(posedge clk) begin
		reader_beat_t exp_b;
		if (arst_n && out_valid && !out_stall) begin
			beats_seen++;
			if (beat_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("beat %0d with nothing pending: sclk %b wv %b grams %h nv %b",
						beats_seen, serial_clock, weight_valid, weight_grams,
						no_valid_sample);
			end else begin
				exp_b = beat_q.pop_front();
				if (exp_b.sclk !== serial_clock || exp_b.wvalid !== weight_valid ||
						exp_b.grams !== weight_grams || exp_b.novalid !== no_valid_sample) begin
					mismatches++;
					if (mismatches <= 10)
						$display("beat %0d: exp sclk %b wv %b grams %h nv %b, got %b %b %h %b",
							beats_seen, exp_b.sclk, exp_b.wvalid, exp_b.grams, exp_b.novalid,
							serial_clock, weight_valid, weight_grams, no_valid_sample);
				end
			end
		end
	end

	// give up on a hung run
	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT_CYCLES) begin
			$display("timeout after %0d cycles, %0d beats pending", cycles, beat_q.size());
			$display("load_cell_adc_reader_core_tb failed");
			$finish;
		end
	end

	initial begin
		int rand_base;
		logic [CFG_W-1:0] t;
		logic [CFG_W-1:0] s;
		logic [HIGH_W-1:0] h;
		logic first_phase;

		tare = '0;
		scale = 24'd1;
		high_ticks = 8'd1;
		tr_phase = TR_IDLE;
		bits_in = '0;
		pulse_ticks = '0;
		shift_acc = '0;
		sample_acc = '0;
		good_samples = '0;
		attempts = '0;

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// the unused index must leave the reset values alone
		set_regs('0, '0, '0, 4'b1000);

		// directed weighings
		for (int r = 0; r < $size(plan); r++) begin
			if (plan[r].wr) begin
				drain();
				set_regs(plan[r].tare_v, plan[r].scale_v, plan[r].high_v, 4'b0111);
			end
			typed_on = plan[r].typed;
			typed_grams = plan[r].grams;
			typed_nv = plan[r].novalid;
			convert(plan[r].word_a, int'(plan[r].lead));
			convert(plan[r].word_b, int'(plan[r].lead));
		end
		typed_on = 1'b0;

		// random weighings, one register setting per stretch
		rand_base = n_ticks;
		first_phase = 1'b1;
		while (n_ticks - rand_base < RANDOM_TICKS || n_weights < WEIGHT_GOAL) begin
			drain();
			case ($urandom_range(0, 3))
				0:       t = '0;
				1:       t = '1;
				default: t = CFG_W'($urandom);
			endcase
			case ($urandom_range(0, 4))
				0:       s = '0;
				1:       s = 24'd1;
				2:       s = '1;
				default: s = CFG_W'($urandom_range(1, 1 << $urandom_range(1, 23)));
			endcase
			h = ($urandom_range(0, 7) == 0) ? HIGH_W'($urandom_range(4, 6))
				: HIGH_W'($urandom_range(0, 3));
			set_regs(t, s, h, {1'($urandom_range(0, 3) == 0), 3'b111});
			idle_bursts_on = (n_weights < QUIET_AFTER) && ($urandom_range(0, 3) != 0);
			if (first_phase && n_weights >= QUIET_AFTER) begin
				hold_req = 1'b1;
				first_phase = 1'b0;
			end
			convert(pick_word(), $urandom_range(0, 3));
			convert(pick_word(), $urandom_range(0, 3));
		end

		idle_bursts_on = 1'b0;
		drain();
		repeat (SETTLE) @(posedge clk);
		if (beat_q.size() != 0)
			mismatches++;

		$display("covered %0d ticks (%0d taken) and %0d weights: %0d without a good sample,",
			n_ticks, n_accepted, n_weights, n_novalid);
		$display("%0d at or below tare, %0d register writes, %0d beats checked, %0d mismatches",
			n_tared, n_writes, beats_seen, mismatches);
		if (mismatches == 0)
			$display("load_cell_adc_reader_core_tb passed");
		else
			$display("load_cell_adc_reader_core_tb failed");
		$finish;
	end

endmodule
